@@ src/sorted_unique_word_table_top_defines.svh @@
// Assertion macros for the sorted word table
`ifndef SORTED_UNIQUE_WORD_TABLE_TOP_DEFINES_SVH
`define SORTED_UNIQUE_WORD_TABLE_TOP_DEFINES_SVH
`define SUWT_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SUWT_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ src/suwt_pkg.sv @@
// ----------------------------------------------------------------------------
// suwt_pkg
// Types and constants for the sorted unique word table.
// ----------------------------------------------------------------------------
`default_nettype none
package suwt_pkg;
   localparam int MaxEntries = 4096;
   localparam int MaxWordLen = 32;
   localparam int IdxW = $clog2(MaxEntries);
   localparam int CntW = $clog2(MaxEntries + 1);
   localparam int PosW = $clog2(MaxWordLen);
   localparam int LenW = $clog2(MaxWordLen + 1);
   localparam int AddrW = IdxW + PosW;

   typedef enum logic [1:0] {
      KIND_TEXT  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_FLUSH = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CMP_RD,
      ST_CMP,
      ST_SH_RD,
      ST_SH_WR,
      ST_INS,
      ST_RD_LEN,
      ST_RD_CH,
      ST_RD_OUT
   } state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] text_byte;
      logic [IdxW-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [7:0] word_char;
      logic is_last;
      logic entry_valid;
      logic [CntW-1:0] word_count;
   } rsp_type;
endpackage
`default_nettype wire

@@ src/suwt_if.sv @@
// ----------------------------------------------------------------------------
// suwt_req_if / suwt_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface suwt_req_if import suwt_pkg::*; ();
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface suwt_rsp_if import suwt_pkg::*; ();
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/sorted_unique_word_table_top.sv @@
// A text request is handled in ST_IDLE; a word end compares entry by entry
// (ST_CMP_RD, then ST_CMP letter by letter), shifts later entries up one letter
// per ST_SH_RD/ST_SH_WR pair and writes the new word one letter a cycle.
// Reads give one char per ST_RD_CH/ST_RD_OUT pass. One request at a time; single-port memories.
// Synchronous active-high reset clears count, pending length, result valid and FSM.
// ----------------------------------------------------------------------------
// sorted_unique_word_table_top
// Sorted, deduplicated word table built from a byte stream.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_unique_word_table_top import suwt_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   suwt_req_if.sink req,
   suwt_rsp_if.source rsp
);
   logic [7:0] letter_mem [MaxEntries*MaxWordLen];
   logic [LenW-1:0] len_mem [MaxEntries];
   logic [7:0] pend_mem [MaxWordLen];

   state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [LenW-1:0] plen_ff, plen_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic [CntW-1:0] sh_ff, sh_in;
   logic [LenW-1:0] k_ff, k_in;
   logic [LenW-1:0] elen_ff, elen_in;
   logic [IdxW-1:0] ridx_ff, ridx_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [7:0] lrd_ff, prd_ff;
   logic [LenW-1:0] lenrd_ff;
   logic [AddrW-1:0] laddr;
   logic lwe;
   logic [7:0] lwd;
   logic [IdxW-1:0] len_addr;
   logic len_we;
   logic [LenW-1:0] len_wd;
   logic [PosW-1:0] paddr;
   logic pwe;

   logic [7:0] lc;
   logic is_letter;
   logic [LenW-1:0] ml;

   always_ff @(posedge clock) begin
      if (lwe) letter_mem[laddr] <= lwd;
      lrd_ff <= letter_mem[laddr];
      if (len_we) len_mem[len_addr] <= len_wd;
      lenrd_ff <= len_mem[len_addr];
      if (pwe) pend_mem[paddr] <= lc;
      prd_ff <= pend_mem[paddr];
   end

   always_comb begin
      lc = req.data.text_byte;
      if (lc inside {[8'h41:8'h5a]}) lc = lc | 8'h20;
      is_letter = lc inside {[8'h61:8'h7a]};
      ml = (lenrd_ff < plen_ff) ? lenrd_ff : plen_ff;
   end

   assign req.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      plen_in = plen_ff;
      pos_in = pos_ff;
      sh_in = sh_ff;
      k_in = k_ff;
      elen_in = elen_ff;
      ridx_in = ridx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in = rsp_ff;
      laddr = {pos_ff[IdxW-1:0], k_ff[PosW-1:0]};
      lwe = 1'b0;
      lwd = lrd_ff;
      len_addr = pos_ff[IdxW-1:0];
      len_we = 1'b0;
      len_wd = lenrd_ff;
      paddr = k_ff[PosW-1:0];
      pwe = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               pos_in = '0;
               k_in = '0;
               case (req.data.kind)
                  KIND_TEXT: begin
                     if (is_letter) begin
                        if (plen_ff < LenW'(MaxWordLen)) begin
                           paddr = plen_ff[PosW-1:0];
                           pwe = 1'b1;
                           plen_in = plen_ff + 1'b1;
                        end
                     end else if (plen_ff != 0) begin
                        state_in = ST_CMP_RD;
                     end
                  end
                  KIND_FLUSH: if (plen_ff != 0) state_in = ST_CMP_RD;
                  KIND_READ: begin
                     ridx_in = req.data.entry_index;
                     if ({1'b0, req.data.entry_index} >= count_ff) begin
                        rsp_in = '{8'd0, 1'b1, 1'b0, count_ff};
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_RD_LEN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CMP_RD: begin
            if (pos_ff >= count_ff) begin
               state_in = (count_ff < CntW'(MaxEntries)) ? ST_SH_RD : ST_IDLE;
               if (count_ff >= CntW'(MaxEntries)) plen_in = '0;
               sh_in = count_ff;
               k_in = '0;
            end else begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (k_ff == ml) begin
               if (lenrd_ff == plen_ff) begin
                  plen_in = '0;
                  state_in = ST_IDLE;
               end else if (lenrd_ff < plen_ff) begin
                  pos_in = pos_ff + 1'b1;
                  k_in = '0;
                  state_in = ST_CMP_RD;
               end else begin
                  state_in = (count_ff < CntW'(MaxEntries)) ? ST_SH_RD : ST_IDLE;
                  if (count_ff >= CntW'(MaxEntries)) plen_in = '0;
                  sh_in = count_ff;
                  k_in = '0;
               end
            end else if (lrd_ff != prd_ff) begin
               if (lrd_ff < prd_ff) begin
                  pos_in = pos_ff + 1'b1;
                  k_in = '0;
                  state_in = ST_CMP_RD;
               end else begin
                  state_in = (count_ff < CntW'(MaxEntries)) ? ST_SH_RD : ST_IDLE;
                  if (count_ff >= CntW'(MaxEntries)) plen_in = '0;
                  sh_in = count_ff;
                  k_in = '0;
               end
            end else begin
               k_in = k_ff + 1'b1;
               laddr = {pos_ff[IdxW-1:0], k_in[PosW-1:0]};
               paddr = k_in[PosW-1:0];
            end
         end
         ST_SH_RD: begin
            if (sh_ff == pos_ff) begin
               k_in = '0;
               paddr = '0;
               state_in = ST_INS;
            end else begin
               laddr = {sh_in[IdxW-1:0] - 1'b1, k_ff[PosW-1:0]};
               len_addr = sh_ff[IdxW-1:0] - 1'b1;
               state_in = ST_SH_WR;
            end
         end
         ST_SH_WR: begin
            laddr = {sh_ff[IdxW-1:0], k_ff[PosW-1:0]};
            lwe = 1'b1;
            if (k_ff == 0) begin
               len_addr = sh_ff[IdxW-1:0];
               len_we = 1'b1;
               elen_in = lenrd_ff;
            end
            if (k_ff + 1'b1 >= ((k_ff == 0) ? lenrd_ff : elen_ff)) begin
               k_in = '0;
               sh_in = sh_ff - 1'b1;
            end else begin
               k_in = k_ff + 1'b1;
            end
            state_in = ST_SH_RD;
         end
         ST_INS: begin
            // prd_ff holds pending[k]
            if (k_ff == plen_ff) begin
               len_addr = pos_ff[IdxW-1:0];
               len_we = 1'b1;
               len_wd = plen_ff;
               count_in = count_ff + 1'b1;
               plen_in = '0;
               state_in = ST_IDLE;
            end else begin
               laddr = {pos_ff[IdxW-1:0], k_ff[PosW-1:0]};
               lwe = 1'b1;
               lwd = prd_ff;
               k_in = k_ff + 1'b1;
               paddr = k_in[PosW-1:0];
            end
         end
         ST_RD_LEN: begin
            len_addr = ridx_ff;
            k_in = '0;
            state_in = ST_RD_CH;
         end
         ST_RD_CH: begin
            if (k_ff == 0) elen_in = lenrd_ff;
            laddr = {ridx_ff, k_ff[PosW-1:0]};
            state_in = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            laddr = {ridx_ff, k_ff[PosW-1:0]};
            if (!rsp_valid_ff) begin
               rsp_in = '{lrd_ff, (k_ff + 1'b1 == elen_ff), 1'b1, count_ff};
               rsp_valid_in = 1'b1;
               k_in = k_ff + 1'b1;
               state_in = (k_ff + 1'b1 == elen_ff) ? ST_IDLE : ST_RD_CH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         plen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         plen_ff <= plen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff <= pos_in;
      sh_ff <= sh_in;
      k_ff <= k_in;
      elen_ff <= elen_in;
      ridx_ff <= ridx_in;
      rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

@@ src/suwt_checker.sv @@
// ----------------------------------------------------------------------------
// suwt_checker
// Port-level checks for the sorted word table.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_unique_word_table_top_defines.svh"
module suwt_checker import suwt_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire rsp_type rsp_data
);
   `SUWT_ASSERT_RST(a_rst_idle, clock, reset |=> !rsp_valid, "rsp valid after reset")
   `SUWT_ASSERT_IMPL(a_hold, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp held")
   `SUWT_ASSERT_IMPL(a_bound, clock, reset, rsp_valid |-> rsp_data.word_count <= CntW'(MaxEntries), "count range")
   `SUWT_ASSERT_IMPL(a_inv, clock, reset, rsp_valid && !rsp_data.entry_valid |-> rsp_data.is_last, "invalid not last")
   `SUWT_ASSERT_IMPL(a_busy, clock, reset, rsp_valid |-> !req_ready, "accept while result pending")
endmodule

bind sorted_unique_word_table_top suwt_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);
`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives text, flush and read requests into the sorted unique word table and
// checks every returned character against a behavioral model of the table.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   import suwt_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   suwt_req_if req_ch ();
   suwt_rsp_if rsp_ch ();

   sorted_unique_word_table_top DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always #5 clock = ~clock;

   // model of the table
   logic [7:0] word_letters [$][$];
   logic [7:0] open_word [$];
   rsp_type    expected_chars [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int failures = 0;
   int requests_sent = 0;
   int chars_checked = 0;

   // <0 entry before open word, 0 equal, >0 after
   function automatic int order_vs_open(int e);
      int n;
      n = (word_letters[e].size() < open_word.size()) ?
          word_letters[e].size() : open_word.size();
      for (int i = 0; i < n; i++)
         if (word_letters[e][i] != open_word[i])
            return (word_letters[e][i] < open_word[i]) ? -1 : 1;
      if (word_letters[e].size() == open_word.size()) return 0;
      return (word_letters[e].size() < open_word.size()) ? -1 : 1;
   endfunction

   function automatic void close_word();
      int pos;
      int r;
      pos = 0;
      r = -1;
      if (open_word.size() == 0) return;
      while (pos < word_letters.size()) begin
         r = order_vs_open(pos);
         if (r >= 0) break;
         pos++;
      end
      if (!(pos < word_letters.size() && r == 0) && word_letters.size() < MaxEntries)
         word_letters.insert(pos, open_word);
      open_word.delete();
   endfunction

   function automatic void predict_table(req_type q);
      logic [7:0] ch;
      rsp_type    r;
      int         len;
      ch = q.text_byte;
      case (q.kind)
         KIND_TEXT: begin
            if (ch >= "A" && ch <= "Z") ch = ch - "A" + "a";
            if (ch >= "a" && ch <= "z") begin
               if (open_word.size() < MaxWordLen) open_word.push_back(ch);
            end else begin
               close_word();
            end
         end
         KIND_FLUSH: close_word();
         KIND_READ: begin
            r.word_count = CntW'(word_letters.size());
            if (q.entry_index >= word_letters.size()) begin
               r.word_char = 8'd0;
               r.is_last = 1'b1;
               r.entry_valid = 1'b0;
               expected_chars.push_back(r);
            end else begin
               len = word_letters[q.entry_index].size();
               for (int k = 0; k < len; k++) begin
                  r.word_char = word_letters[q.entry_index][k];
                  r.is_last = (k + 1 == len);
                  r.entry_valid = 1'b1;
                  expected_chars.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_request(logic [1:0] kind, logic [7:0] b, logic [IdxW-1:0] idx);
      req_type q;
      q.kind = kind;
      q.text_byte = b;
      q.entry_index = idx;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= q;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_table(q);
      requests_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_request(KIND_TEXT, s[i], '0);
   endtask

   task automatic read_all();
      int n;
      n = word_letters.size();
      for (int i = 0; i <= n; i++) send_request(KIND_READ, 8'h00, IdxW'(i));
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      while (guard < 200) begin
         @(posedge clock);
         guard++;
      end
   endtask

   // receiver side
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         chars_checked++;
         if (expected_chars.size() == 0) begin
            $error("unexpected result char=%0h", rsp_ch.data.word_char);
            failures++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_ch.data.word_char !== want.word_char) begin
               $error("word_char exp %0h got %0h", want.word_char, rsp_ch.data.word_char);
               failures++;
            end
            if (rsp_ch.data.is_last !== want.is_last) begin
               $error("is_last exp %0b got %0b", want.is_last, rsp_ch.data.is_last);
               failures++;
            end
            if (rsp_ch.data.entry_valid !== want.entry_valid) begin
               $error("entry_valid exp %0b got %0b", want.entry_valid,
                  rsp_ch.data.entry_valid);
               failures++;
            end
            if (rsp_ch.data.word_count !== want.word_count) begin
               $error("word_count exp %0d got %0d", want.word_count,
                  rsp_ch.data.word_count);
               failures++;
            end
         end
      end
   end

   task automatic test_directed();
      send_request(KIND_READ, 8'h00, '0);
      send_request(KIND_READ, 8'hff, '1);
      send_text("Zeta alpha ALPHA al");
      send_request(KIND_FLUSH, 8'h00, '0);
      send_request(KIND_FLUSH, 8'h00, '0);
      send_text("abcdefghijklmnopqrstuvwxyzABCDEFGHIJ");
      send_request(KIND_TEXT, 8'hff, '0);
      send_request(KIND_TEXT, "b", '0);
      send_request(KIND_TEXT, 8'h80, '0);
      send_request(2'd3, 8'hff, '1);
      read_all();
   endtask

   task automatic test_random_words(int n);
      int sent;
      int len;
      logic [7:0] c;
      sent = 0;
      while (sent < n) begin
         case ($urandom_range(9))
            0: begin
               send_request(KIND_TEXT, 8'($urandom), IdxW'($urandom));
               sent++;
            end
            1: begin
               send_request(KIND_READ, 8'($urandom),
                  ($urandom_range(3) == 0) ? IdxW'($urandom) :
                  IdxW'($urandom_range(word_letters.size())));
               sent++;
            end
            2: begin
               send_request(($urandom_range(1) == 0) ? KIND_FLUSH : 2'd3,
                  8'($urandom), IdxW'($urandom));
               sent++;
            end
            default: begin
               len = ($urandom_range(15) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 4);
               for (int i = 0; i < len; i++) begin
                  c = 8'($urandom_range(3)) + (($urandom_range(1) == 0) ? "a" : "A");
                  send_request(KIND_TEXT, c, IdxW'($urandom));
               end
               send_request(KIND_TEXT, ($urandom_range(1) == 0) ? " " : 8'($urandom_range(128, 255)),
                  IdxW'($urandom));
               sent += len + 1;
            end
         endcase
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 400;
      read_all();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 17;
      recv_idle_pct = 75;
      test_directed();
      wait_drained();
      test_random_words(15);
      send_idle_pct = 75;
      recv_idle_pct = 17;
      test_random_words(15);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_words(15);
      test_backpressure();
      wait_drained();
      $display("Sent %0d requests, checked %0d result chars, %0d words in table.",
         requests_sent, chars_checked, word_letters.size());
      if (failures == 0) begin
         $display("sorted_unique_word_table_top verification clean");
      end else begin
         $display("sorted_unique_word_table_top verification failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("sorted_unique_word_table_top verification failed");
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+src
src/suwt_pkg.sv
src/suwt_if.sv
src/sorted_unique_word_table_top.sv
src/suwt_checker.sv
tb/sv/testbench.sv
